// File: sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low
`define SNZ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("snz check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low
`define SNZ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("snz check failed");

`endif

// File: sv/snz_pkg.sv
// Shared types, constants and lookup functions of the simplex noise core
`timescale 1ns / 1ps
package snz_pkg;

	localparam int OFS_BITS   = 24;
	localparam int QW         = 28;
	localparam int QS_W       = OFS_BITS + 1;
	localparam int DP_W       = QS_W + 2;
	localparam int SQ_W       = 2 * OFS_BITS;
	localparam int TW         = 30;
	localparam int CT_W       = TW + 1 + DP_W;
	localparam int ACC_W      = CT_W + 2;
	localparam int NCORN      = 4;
	localparam int FIFO_DEPTH = 4;

	localparam logic [SQ_W-1:0] FALLOFF_R2 = SQ_W'(((64'd3 << SQ_W) + 64'd2) / 64'd5);
	localparam logic [QW-1:0] CORNER_STEP = QW'((64'd1 << OFS_BITS) / 64'd6);
	localparam logic [QW-1:0] CORNER_UNIT = QW'(64'd1 << OFS_BITS);

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};

	typedef struct packed {
		logic [2:0] c1;
		logic [2:0] c2;
	} snz_order_t;

	typedef logic [3:0] snz_grad_t;

	// Lattice step of corner n: bit 0 x, bit 1 y, bit 2 z
	function automatic logic [2:0] corner_d(input snz_order_t o, input logic [1:0] n);
		logic [2:0] d;
		begin
			case (n)
				2'd0: d = 3'b000;
				2'd1: d = o.c1;
				2'd2: d = o.c2;
				default: d = 3'b111;
			endcase
			return d;
		end
	endfunction

	function automatic snz_grad_t mod12(input logic [7:0] h);
		logic [7:0] r;
		begin
			r = h;
			for (int k = 4; k >= 0; k--) begin
				if (r >= (8'd12 << k)) begin
					r = r - (8'd12 << k);
				end
			end
			return r[3:0];
		end
	endfunction

	function automatic logic signed [DP_W-1:0] grad_dot(input snz_grad_t g,
			input logic signed [QS_W-1:0] qx, input logic signed [QS_W-1:0] qy,
			input logic signed [QS_W-1:0] qz);
		logic signed [DP_W-1:0] x, y, z, r;
		begin
			x = DP_W'(qx);
			y = DP_W'(qy);
			z = DP_W'(qz);
			case (g)
				4'd0:  r =  x + y;
				4'd1:  r = -x + y;
				4'd2:  r =  x - y;
				4'd3:  r = -x - y;
				4'd4:  r =  x + z;
				4'd5:  r = -x + z;
				4'd6:  r =  x - z;
				4'd7:  r = -x - z;
				4'd8:  r =  y + z;
				4'd9:  r = -y + z;
				4'd10: r =  y - z;
				4'd11: r = -y - z;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: sv/snz_front.sv
// Front end: skew, exact floor to the cell, cell offsets and corner order
`timescale 1ns / 1ps
module snz_front #(
	parameter int FRAC_BITS = 16,
	localparam int OW = FRAC_BITS + 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pt_valid,
	output logic                    pt_ready,
	input  logic signed [31:0]      px,
	input  logic signed [31:0]      py,
	input  logic signed [31:0]      pz,
	output logic                    cell_valid,
	input  logic                    cell_ready,
	output logic signed [OW-1:0]    x0,
	output logic signed [OW-1:0]    y0,
	output logic signed [OW-1:0]    z0,
	output logic [7:0]              ii,
	output logic [7:0]              jj,
	output logic [7:0]              kk,
	output snz_pkg::snz_order_t     order
);
	import snz_pkg::*;

	localparam int MB = 35 - FRAC_BITS;
	localparam int NU = MB + 1;
	localparam int SR = NU + 2;
	localparam logic [NU:0]   RCP  = (NU+1)'(((64'd1 << SR) + 64'd2) / 64'd3);
	localparam logic [NU-1:0] BIAS = NU'(64'd3 << (MB - 1));

	logic [3:1] vld_q;
	logic adv;

	logic [NU-1:0]     u_c   [3];
	logic [NU-1:0]     u_s1  [3];
	logic [OW-1:0]     xl_s1 [3];
	logic [2*NU:0]     prod_s2 [3];
	logic [OW-1:0]     xl_s2 [3];
	logic [OW-1:0]     ofs_c [3];
	logic [OW-1:0]     ofs_s3 [3];
	logic [7:0]        cell_c [3];
	logic [7:0]        cell_s3 [3];

	function automatic logic [NU-1:0] skew_u(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] c);
		logic signed [34:0] sk;
		begin
			sk = (35'(a) <<< 2) + 35'(b) + 35'(c);
			return {sk[34], sk[34:FRAC_BITS]} + BIAS;
		end
	endfunction

	assign adv      = !vld_q[3] || cell_ready;
	assign pt_ready = adv;

	always_comb begin
		u_c[0] = skew_u(px, py, pz);
		u_c[1] = skew_u(py, px, pz);
		u_c[2] = skew_u(pz, px, py);
	end

	always_comb begin
		logic [5:0] i6 [3];
		logic [5:0] s6;
		logic [5:0] t6;
		for (int a = 0; a < 3; a++) begin
			i6[a] = prod_s2[a][SR+5:SR];
		end
		s6 = i6[0] + i6[1] + i6[2];
		for (int a = 0; a < 3; a++) begin
			t6 = (i6[a] << 1) + (i6[a] << 2) - s6;
			cell_c[a] = prod_s2[a][SR+7:SR];
			ofs_c[a]  = (xl_s2[a] << 1) + (xl_s2[a] << 2) - {t6, {FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[2:1], pt_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1     <= u_c;
			xl_s1[0] <= px[OW-1:0];
			xl_s1[1] <= py[OW-1:0];
			xl_s1[2] <= pz[OW-1:0];
			for (int a = 0; a < 3; a++) begin
				prod_s2[a] <= u_s1[a] * RCP;
			end
			xl_s2   <= xl_s1;
			ofs_s3  <= ofs_c;
			cell_s3 <= cell_c;
		end
	end

	assign cell_valid = vld_q[3];
	assign x0 = ofs_s3[0];
	assign y0 = ofs_s3[1];
	assign z0 = ofs_s3[2];
	assign ii = cell_s3[0];
	assign jj = cell_s3[1];
	assign kk = cell_s3[2];

	always_comb begin
		if (x0 >= y0) begin
			if (y0 >= z0) begin
				order = '{c1: 3'b001, c2: 3'b011};
			end else if (x0 >= z0) begin
				order = '{c1: 3'b001, c2: 3'b101};
			end else begin
				order = '{c1: 3'b100, c2: 3'b101};
			end
		end else begin
			if (y0 < z0) begin
				order = '{c1: 3'b100, c2: 3'b110};
			end else if (x0 < z0) begin
				order = '{c1: 3'b010, c2: 3'b110};
			end else begin
				order = '{c1: 3'b010, c2: 3'b011};
			end
		end
	end

endmodule

// File: sv/snz_fifo.sv
// Short queue between the front end and the back end
`timescale 1ns / 1ps
module snz_fifo #(
	parameter int W = 96
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	import snz_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CW'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/snz_back.sv
// Back end: corner offsets, gradient hashing, falloff and summation
`timescale 1ns / 1ps
module snz_back #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_BITS = 16,
	localparam int OW = FRAC_BITS + 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cell_valid,
	output logic                        cell_ready,
	input  logic signed [OW-1:0]        x0,
	input  logic signed [OW-1:0]        y0,
	input  logic signed [OW-1:0]        z0,
	input  logic [7:0]                  ii,
	input  logic [7:0]                  jj,
	input  logic [7:0]                  kk,
	input  snz_pkg::snz_order_t         order,
	output logic                        noise_valid,
	input  logic                        noise_ready,
	output logic signed [OUT_BITS-1:0]  noise
);
	import snz_pkg::*;

	localparam int SR = QW + 2;
	localparam logic [QW:0]   RQ    = (QW+1)'(((64'd1 << SR) + 64'd2) / 64'd3);
	localparam logic [QW-1:0] UBIAS = QW'(64'd3 << (QW - 2));
	localparam logic [QW-1:0] QBIAS = QW'(64'd1 << (QW - 2));
	localparam int SH = 2 * OFS_BITS + 2 - OUT_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (SH - 1));
	localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
	localparam logic signed [ACC_W-1:0] MINV = -(MAXV + ACC_W'(1));

	logic [11:1] vld_q;
	logic adv;

	logic [QW-1:0]      u_c    [3];
	logic [2:0]         xlo_c  [3];
	logic [QW-1:0]      u_s1   [3];
	logic [2:0]         xlo_s1 [3];
	logic [7:0]         ii_s1, jj_s1, kk_s1;
	snz_order_t         order_s1;

	logic [7:0]         h1_c  [NCORN];
	logic [2*QW:0]      prod_s2 [3];
	logic [2:0]         xlo_s2 [3];
	logic [7:0]         ii_s2, jj_s2;
	snz_order_t         order_s2;
	logic [7:0]         h1_s2 [NCORN];

	logic [7:0]         h2_c  [NCORN];
	logic signed [QW-1:0] q0_c [3];
	logic [2:0]         r0_c  [3];
	logic signed [QW-1:0] q0_s3 [3];
	logic [2:0]         r0_s3 [3];
	logic [7:0]         ii_s3;
	snz_order_t         order_s3;
	logic [7:0]         h2_s3 [NCORN];

	snz_grad_t          g_c  [NCORN];
	logic signed [QW-1:0] q_c [NCORN][3];
	logic signed [QW-1:0] q_s4 [NCORN][3];
	snz_grad_t          g_s4 [NCORN];

	logic [SQ_W-1:0]    sq_c  [NCORN][3];
	logic               big_c [NCORN];
	logic signed [DP_W-1:0] dp_c [NCORN];
	logic [SQ_W-1:0]    sq_s5 [NCORN][3];
	logic               big_s5 [NCORN];
	logic signed [DP_W-1:0] dp_s5 [NCORN];

	logic [TW-1:0]      t_c    [NCORN];
	logic               live_c [NCORN];
	logic [TW-1:0]      t_s6   [NCORN];
	logic               live_s6 [NCORN];
	logic signed [DP_W-1:0] dp_s6 [NCORN];

	logic [TW-1:0]      t2_c   [NCORN];
	logic [TW-1:0]      t2_s7  [NCORN];
	logic               live_s7 [NCORN];
	logic signed [DP_W-1:0] dp_s7 [NCORN];

	logic [TW-1:0]      t4_c   [NCORN];
	logic [TW-1:0]      t4_s8  [NCORN];
	logic signed [DP_W-1:0] dp_s8 [NCORN];

	logic signed [CT_W-1:0] ct_c  [NCORN];
	logic signed [CT_W-1:0] ct_s9 [NCORN];
	logic signed [ACC_W-1:0] acc_c, acc_s10;
	logic signed [OUT_BITS-1:0] noise_c, noise_s11;

	assign adv        = !vld_q[11] || noise_ready;
	assign cell_ready = adv;

	always_comb begin
		logic signed [31:0] xe [3];
		logic signed [31:0] xs;
		xe[0] = 32'(x0);
		xe[1] = 32'(y0);
		xe[2] = 32'(z0);
		for (int a = 0; a < 3; a++) begin
			xs = (xe[a] <<< (OFS_BITS - FRAC_BITS)) + 32'sd3;
			xlo_c[a] = xs[2:0];
			u_c[a] = {xs[QW-1], xs[QW-1:1]} + UBIAS;
		end
	end

	always_comb begin
		logic [2:0] d;
		for (int n = 0; n < NCORN; n++) begin
			d = corner_d(order_s1, 2'(n));
			h1_c[n] = PERM[kk_s1 + {7'd0, d[2]}];
		end
	end

	always_comb begin
		logic [2:0] d;
		for (int n = 0; n < NCORN; n++) begin
			d = corner_d(order_s2, 2'(n));
			h2_c[n] = PERM[jj_s2 + {7'd0, d[1]} + h1_s2[n]];
		end
		for (int a = 0; a < 3; a++) begin
			q0_c[a] = {1'b0, prod_s2[a][SR+QW-2:SR]} - QBIAS;
			r0_c[a] = xlo_s2[a] - ({q0_c[a][1:0], 1'b0} + {q0_c[a][0], 2'b00});
		end
	end

	always_comb begin
		logic [2:0] d;
		logic [4:0] r;
		logic [QW-1:0] corr;
		for (int n = 0; n < NCORN; n++) begin
			d = corner_d(order_s3, 2'(n));
			g_c[n] = mod12(PERM[ii_s3 + {7'd0, d[0]} + h2_s3[n]]);
			for (int a = 0; a < 3; a++) begin
				r = {2'b00, r0_s3[a]} + 5'(4 * n);
				corr = (r >= 5'd12) ? QW'(2) : ((r >= 5'd6) ? QW'(1) : QW'(0));
				q_c[n][a] = q0_s3[a] + QW'(n) * CORNER_STEP + corr
					- (d[a] ? CORNER_UNIT : '0);
			end
		end
	end

	always_comb begin
		logic signed [QS_W-1:0] qs [3];
		logic signed [2*QS_W-1:0] p;
		for (int n = 0; n < NCORN; n++) begin
			big_c[n] = 1'b0;
			for (int a = 0; a < 3; a++) begin
				qs[a] = q_s4[n][a][QS_W-1:0];
				p = qs[a] * qs[a];
				sq_c[n][a] = p[SQ_W-1:0];
				if (q_s4[n][a] >= $signed(CORNER_UNIT) || q_s4[n][a] <= -$signed(CORNER_UNIT)) begin
					big_c[n] = 1'b1;
				end
			end
			dp_c[n] = grad_dot(g_s4[n], qs[0], qs[1], qs[2]);
		end
	end

	always_comb begin
		logic [SQ_W+1:0] r2;
		logic [SQ_W+1:0] tt;
		for (int n = 0; n < NCORN; n++) begin
			r2 = (SQ_W+2)'(sq_s5[n][0]) + (SQ_W+2)'(sq_s5[n][1]) + (SQ_W+2)'(sq_s5[n][2]);
			tt = (SQ_W+2)'(FALLOFF_R2) - r2;
			live_c[n] = !big_s5[n] && (r2 < (SQ_W+2)'(FALLOFF_R2));
			t_c[n] = tt[SQ_W-1:SQ_W-TW];
		end
	end

	always_comb begin
		logic [2*TW-1:0] m2, m4;
		logic signed [TW:0] te;
		for (int n = 0; n < NCORN; n++) begin
			m2 = t_s6[n] * t_s6[n];
			t2_c[n] = m2[2*TW-1:TW];
			m4 = t2_s7[n] * t2_s7[n];
			t4_c[n] = live_s7[n] ? m4[2*TW-1:TW] : '0;
			te = $signed({1'b0, t4_s8[n]});
			ct_c[n] = te * dp_s8[n];
		end
	end

	always_comb begin
		logic signed [ACC_W-1:0] rs;
		acc_c = '0;
		for (int n = 0; n < NCORN; n++) begin
			acc_c = acc_c + ACC_W'(ct_s9[n]);
		end
		rs = (acc_s10 + HALF) >>> SH;
		if (rs > MAXV) begin
			noise_c = MAXV[OUT_BITS-1:0];
		end else if (rs < MINV) begin
			noise_c = MINV[OUT_BITS-1:0];
		end else begin
			noise_c = rs[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[10:1], cell_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1     <= u_c;
			xlo_s1   <= xlo_c;
			ii_s1    <= ii;
			jj_s1    <= jj;
			kk_s1    <= kk;
			order_s1 <= order;

			for (int a = 0; a < 3; a++) begin
				prod_s2[a] <= u_s1[a] * RQ;
			end
			xlo_s2   <= xlo_s1;
			ii_s2    <= ii_s1;
			jj_s2    <= jj_s1;
			order_s2 <= order_s1;
			h1_s2    <= h1_c;

			q0_s3    <= q0_c;
			r0_s3    <= r0_c;
			ii_s3    <= ii_s2;
			order_s3 <= order_s2;
			h2_s3    <= h2_c;

			q_s4     <= q_c;
			g_s4     <= g_c;

			sq_s5    <= sq_c;
			big_s5   <= big_c;
			dp_s5    <= dp_c;

			t_s6     <= t_c;
			live_s6  <= live_c;
			dp_s6    <= dp_s5;

			t2_s7    <= t2_c;
			live_s7  <= live_s6;
			dp_s7    <= dp_s6;

			t4_s8    <= t4_c;
			dp_s8    <= dp_s7;

			ct_s9    <= ct_c;
			acc_s10  <= acc_c;
			noise_s11 <= noise_c;
		end
	end

	assign noise_valid = vld_q[11];
	assign noise       = noise_s11;

endmodule

// File: sv/simplex_noise_3d_core.sv
// Top level of the 3D simplex noise core
//
//   beat     valid        ready        payload
//   point    pt_valid     pt_ready     px, py, pz  (signed Q16.16 at default FRAC_BITS)
//   result   noise_valid  noise_ready  noise       (signed Q1.15 at default OUT_BITS)
//
// One point per cycle sustained while noise_ready is held high.
// Front end: 3 stages (skew, divide by three, cell offsets); back end: 11 stages.
// A four-beat queue lets the front end keep taking points while the result is held.
// arst_n clears valid flags and queue pointers; no clearing pass.
// A held result stalls the back end, the queue then fills and pt_ready drops.
`timescale 1ns / 1ps
module simplex_noise_3d_core #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pt_valid,
	output logic                        pt_ready,
	input  logic signed [31:0]          px,
	input  logic signed [31:0]          py,
	input  logic signed [31:0]          pz,
	output logic                        noise_valid,
	input  logic                        noise_ready,
	output logic signed [OUT_BITS-1:0]  noise
);
	import snz_pkg::*;

	localparam int OW = FRAC_BITS + 6;
	localparam int EW = 3 * OW + 24 + $bits(snz_order_t);

	logic signed [OW-1:0] f_x0, f_y0, f_z0, b_x0, b_y0, b_z0;
	logic [7:0] f_ii, f_jj, f_kk, b_ii, b_jj, b_kk;
	snz_order_t f_order, b_order;
	logic f_valid, f_ready, b_valid, b_ready;
	logic [EW-1:0] push_data, pop_data;

	snz_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_ready   (pt_ready),
		.px         (px),
		.py         (py),
		.pz         (pz),
		.cell_valid (f_valid),
		.cell_ready (f_ready),
		.x0         (f_x0),
		.y0         (f_y0),
		.z0         (f_z0),
		.ii         (f_ii),
		.jj         (f_jj),
		.kk         (f_kk),
		.order      (f_order)
	);

	assign push_data = {f_x0, f_y0, f_z0, f_ii, f_jj, f_kk, f_order};

	snz_fifo #(.W(EW)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (pop_data)
	);

	assign {b_x0, b_y0, b_z0, b_ii, b_jj, b_kk, b_order} = pop_data;

	snz_back #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (b_valid),
		.cell_ready  (b_ready),
		.x0          (b_x0),
		.y0          (b_y0),
		.z0          (b_z0),
		.ii          (b_ii),
		.jj          (b_jj),
		.kk          (b_kk),
		.order       (b_order),
		.noise_valid (noise_valid),
		.noise_ready (noise_ready),
		.noise       (noise)
	);

endmodule

// File: sv/snz_checker.sv
// Port-level checks of the simplex noise core and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"
module snz_checker #(
	parameter int OUT_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                pt_valid,
	input logic                pt_ready,
	input logic                noise_valid,
	input logic                noise_ready,
	input logic [OUT_BITS-1:0] noise
);

	`SNZ_ASSERT_NEXT(a_pt_hold, pt_valid && !pt_ready, pt_valid)
	`SNZ_ASSERT_NEXT(a_noise_hold, noise_valid && !noise_ready, noise_valid)
	`SNZ_ASSERT_NEXT(a_noise_stable, noise_valid && !noise_ready, $stable(noise))
	`SNZ_ASSERT_NOW(a_stall_source, !pt_ready, $past(noise_valid && !noise_ready))
	`SNZ_ASSERT_NOW(a_no_early_beat, $rose(arst_n), !noise_valid)

endmodule

bind simplex_noise_3d_core snz_checker #(.OUT_BITS(OUT_BITS)) u_snz_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pt_valid    (pt_valid),
	.pt_ready    (pt_ready),
	.noise_valid (noise_valid),
	.noise_ready (noise_ready),
	.noise       (noise)
);
